### sv/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescape / UTF-8 decoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Op codes on the input word
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error causes
  localparam logic [2:0] CAUSE_NONE     = 3'd0;
  localparam logic [2:0] CAUSE_BAD_ESC  = 3'd1;
  localparam logic [2:0] CAUSE_BAD_HEX  = 3'd2;
  localparam logic [2:0] CAUSE_LONE_LOW = 3'd3;
  localparam logic [2:0] CAUSE_NO_PAIR  = 3'd4;
  localparam logic [2:0] CAUSE_BAD_LOW  = 3'd5;
  localparam logic [2:0] CAUSE_UNTERM   = 3'd6;

  // Up to four result words per input word (4-byte UTF-8 sequence)
  localparam int BURST_MAX = 4;
  localparam int CNT_W     = $clog2(BURST_MAX + 1);

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_BODY = 4'd1,
    PH_ESC  = 4'd2,
    PH_HEX1 = 4'd3,
    PH_BSL  = 4'd4,
    PH_U    = 4'd5,
    PH_HEX2 = 4'd6,
    PH_DONE = 4'd7
  } phase_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] in_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [2:0] error_cause;
    logic       last;
  } out_word_t;

  // Decoder state; only the low 12 hex bits need keeping between digits
  typedef struct packed {
    phase_t      phase;
    logic [11:0] hex_value;
    logic [1:0]  hex_count;
    logic [9:0]  high_surr;
  } dec_state_t;

  // Results of one input word, in order
  typedef struct packed {
    logic [CNT_W-1:0]                cnt;
    out_word_t [BURST_MAX-1:0]       w;
  } burst_t;

  // Handshake status from the output buffer
  typedef struct packed {
    logic can_load;
    logic pop;
  } buf_status_t;

endpackage

### sv/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Combinational decode of one input word against the current state: next
// state plus the burst of result words it causes.
// ----------------------------------------------------------------------------
module jsu_decode import jsu_pkg::*; (
  input  dec_state_t st,
  input  in_word_t   item,
  output dec_state_t st_nxt,
  output burst_t     res
);

  function automatic burst_t one_word(logic [1:0] kind, logic [7:0] b, logic [2:0] cause);
    burst_t r;
    r = '0;
    r.cnt = CNT_W'(1);
    r.w[0].kind        = kind;
    r.w[0].out_byte    = b;
    r.w[0].error_cause = cause;
    return r;
  endfunction

  function automatic burst_t utf8_enc(logic [20:0] cp);
    burst_t r;
    r = '0;
    if (cp <= 21'h7F) begin
      r.cnt = CNT_W'(1);
      r.w[0].out_byte = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      r.cnt = CNT_W'(2);
      r.w[0].out_byte = 8'hC0 | {3'b0, cp[10:6]};
      r.w[1].out_byte = 8'h80 | {2'b0, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      r.cnt = CNT_W'(3);
      r.w[0].out_byte = 8'hE0 | {4'b0, cp[15:12]};
      r.w[1].out_byte = 8'h80 | {2'b0, cp[11:6]};
      r.w[2].out_byte = 8'h80 | {2'b0, cp[5:0]};
    end else begin
      // at most 0x10FFFF by construction of the surrogate pair
      r.cnt = CNT_W'(4);
      r.w[0].out_byte = 8'hF0 | {5'b0, cp[20:18]};
      r.w[1].out_byte = 8'h80 | {2'b0, cp[17:12]};
      r.w[2].out_byte = 8'h80 | {2'b0, cp[11:6]};
      r.w[3].out_byte = 8'h80 | {2'b0, cp[5:0]};
    end
    for (int i = 0; i < BURST_MAX; i++) begin
      r.w[i].kind        = KIND_DATA;
      r.w[i].error_cause = CAUSE_NONE;
    end
    return r;
  endfunction

  logic [7:0]  c;
  logic        nib_ok;
  logic [3:0]  nib;
  logic [15:0] hex_acc;
  logic        esc_ok;
  logic [7:0]  esc_b;
  logic        is_hi, is_lo;
  logic [20:0] pair_cp;
  burst_t      raw;

  assign c = item.in_byte;

  // hex digit value
  always_comb begin
    nib_ok = 1'b1;
    nib    = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      nib = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      nib = c[3:0] + 4'd9;
    end else begin
      nib_ok = 1'b0;
    end
  end

  // single-letter escapes
  always_comb begin
    esc_ok = 1'b1;
    case (c)
      8'h22:   esc_b = 8'h22;
      8'h5C:   esc_b = 8'h5C;
      8'h2F:   esc_b = 8'h2F;
      8'h62:   esc_b = 8'h08;
      8'h66:   esc_b = 8'h0C;
      8'h6E:   esc_b = 8'h0A;
      8'h72:   esc_b = 8'h0D;
      8'h74:   esc_b = 8'h09;
      default: begin
        esc_b  = 8'h00;
        esc_ok = 1'b0;
      end
    endcase
  end

  assign hex_acc = {st.hex_value, nib};
  assign is_hi   = (hex_acc >= 16'hD800) && (hex_acc <= 16'hDBFF);
  assign is_lo   = (hex_acc >= 16'hDC00) && (hex_acc <= 16'hDFFF);
  assign pair_cp = 21'h10000 + {1'b0, st.high_surr, hex_acc[9:0]};

  always_comb begin
    st_nxt = st;
    raw    = '0;
    case (item.op)
      OP_START: begin
        st_nxt = '0;
        st_nxt.phase = PH_BODY;
      end
      OP_BYTE, OP_END: begin
        if (st.phase == PH_IDLE || st.phase == PH_DONE) begin
          // ignored
        end else if (item.op == OP_END) begin
          st_nxt.phase = PH_DONE;
          raw = one_word(KIND_ERROR, 8'h00, CAUSE_UNTERM);
        end else begin
          case (st.phase)
            PH_BODY: begin
              if (c == 8'h22) begin
                st_nxt.phase = PH_DONE;
                raw = one_word(KIND_DONE, 8'h00, CAUSE_NONE);
              end else if (c == 8'h5C) begin
                st_nxt.phase = PH_ESC;
              end else begin
                raw = one_word(KIND_DATA, c, CAUSE_NONE);
              end
            end
            PH_ESC: begin
              if (c == 8'h75) begin
                st_nxt.phase     = PH_HEX1;
                st_nxt.hex_value = '0;
                st_nxt.hex_count = '0;
              end else if (!esc_ok) begin
                st_nxt.phase = PH_DONE;
                raw = one_word(KIND_ERROR, 8'h00, CAUSE_BAD_ESC);
              end else begin
                st_nxt.phase = PH_BODY;
                raw = one_word(KIND_DATA, esc_b, CAUSE_NONE);
              end
            end
            PH_BSL: begin
              if (c != 8'h5C) begin
                st_nxt.phase = PH_DONE;
                raw = one_word(KIND_ERROR, 8'h00, CAUSE_NO_PAIR);
              end else begin
                st_nxt.phase = PH_U;
              end
            end
            PH_U: begin
              if (c != 8'h75) begin
                st_nxt.phase = PH_DONE;
                raw = one_word(KIND_ERROR, 8'h00, CAUSE_NO_PAIR);
              end else begin
                st_nxt.phase     = PH_HEX2;
                st_nxt.hex_value = '0;
                st_nxt.hex_count = '0;
              end
            end
            PH_HEX1, PH_HEX2: begin
              if (!nib_ok) begin
                st_nxt.phase = PH_DONE;
                raw = one_word(KIND_ERROR, 8'h00, CAUSE_BAD_HEX);
              end else begin
                st_nxt.hex_value = hex_acc[11:0];
                if (st.hex_count != 2'd3) begin
                  st_nxt.hex_count = st.hex_count + 2'd1;
                end else begin
                  st_nxt.hex_count = '0;
                  if (st.phase == PH_HEX1) begin
                    if (is_hi) begin
                      st_nxt.high_surr = hex_acc[9:0];
                      st_nxt.phase     = PH_BSL;
                    end else if (is_lo) begin
                      st_nxt.phase = PH_DONE;
                      raw = one_word(KIND_ERROR, 8'h00, CAUSE_LONE_LOW);
                    end else begin
                      st_nxt.phase = PH_BODY;
                      raw = utf8_enc({5'b0, hex_acc});
                    end
                  end else if (!is_lo) begin
                    st_nxt.phase = PH_DONE;
                    raw = one_word(KIND_ERROR, 8'h00, CAUSE_BAD_LOW);
                  end else begin
                    st_nxt.phase = PH_BODY;
                    raw = utf8_enc(pair_cp);
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        // unused op code: no effect
      end
    endcase
  end

  // flag the final word of the burst
  always_comb begin
    res = raw;
    for (int i = 0; i < BURST_MAX; i++) begin
      res.w[i].last = (raw.cnt != '0) && (CNT_W'(i) == raw.cnt - CNT_W'(1));
    end
  end

endmodule

### sv/jsu_outbuf.sv
// ----------------------------------------------------------------------------
// jsu_outbuf
// Result register: holds one burst of up to four words and hands them out
// one per accepted output word.
// ----------------------------------------------------------------------------
module jsu_outbuf import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  burst_t      burst,
  input  logic        out_ready,
  output logic        out_valid,
  output out_word_t   out_data,
  output buf_status_t status
);

  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  out_word_t [BURST_MAX-1:0]  buf_r, buf_nxt;

  assign out_valid       = (cnt_r != '0);
  assign out_data        = buf_r[0];
  assign status.pop      = out_valid && out_ready;
  // can take a new burst now if empty, or if draining its final word now
  assign status.can_load = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ready);

  always_comb begin
    cnt_nxt = cnt_r;
    buf_nxt = buf_r;
    if (load) begin
      cnt_nxt = burst.cnt;
      buf_nxt = burst.w;
    end else if (status.pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      for (int i = 0; i < BURST_MAX - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

### sv/json_string_unescape_utf8_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// Streaming JSON string body decoder with UTF-8 output.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid/in_ready/in_data) carry an op and a byte: start a
//   new string, one body byte after the opening quote, or end of buffer.
//   Output words (out_valid/out_ready/out_data) carry a decoded data byte, a
//   string-complete marker or an error with its cause; last marks the final
//   word caused by one input word.
// Results: registered, appearing in the cycle after the input word is taken.
// Throughput: one input word per cycle while out_ready stays high and each
//   word yields at most one result; a \u escape that decodes to several UTF-8
//   bytes holds the input while the single output register drains its burst.
// Stall: when the receiver drops out_ready the burst stays put and in_ready
//   drops once the last buffered word cannot leave this cycle.
// Reset: synchronous, active low; decoder goes idle (ignores everything but
//   a start) and the output buffer empties.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  dec_state_t  st_r, st_nxt;
  burst_t      burst;
  buf_status_t bstat;
  logic        in_acc;

  assign in_ready = bstat.can_load;
  assign in_acc   = in_valid && in_ready;

  // decode: state + input word -> next state + result burst
  jsu_decode u_decode (
    .st     (st_r),
    .item   (in_data),
    .st_nxt (st_nxt),
    .res    (burst)
  );

  // state only moves on an accepted word; all-zero state is the idle phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // result register, serializes multi-byte bursts
  jsu_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_acc),
    .burst     (burst),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (bstat)
  );

  // start always lands in the body phase
  a_start_body: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.op == OP_START |=> st_r.phase == PH_BODY)
    else $error("start did not enter body phase");

  // a stalled result blocks new input
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  // bytes outside a string make no result
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.op == OP_BYTE && (st_r.phase == PH_IDLE || st_r.phase == PH_DONE)
    |=> !out_valid)
    else $error("result from ignored byte");

  // completion and error words stand alone
  a_ctrl_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_DATA |-> out_data.last)
    else $error("control word not marked last");

endmodule
